// ===== hdl/cdft_pkg.sv =====
package cdft_pkg;

  localparam int ROM_POINTS = 64;
  localparam int BIN_W = 6;
  localparam int OUT_W = 24;
  localparam int ACC_W = 48;
  localparam int MAG_W = 24;
  localparam int SQ_W = 48;

  localparam logic CFG_LOG = 1'b0;
  localparam logic CFG_INV = 1'b1;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_CLEAR,
    ST_MAC,
    ST_DRAIN,
    ST_SCALE,
    ST_SQRT,
    ST_EMIT
  } cdft_state_t;

  typedef struct packed {
    logic clear_acc;
    logic mac_en;
    logic scale;
    logic sqrt_start;
    logic sqrt_step;
  } cdft_cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } cdft_sts_t;

  function automatic logic signed [15:0] quarter_cos(input logic [4:0] r);
    logic signed [15:0] v;
    case (r)
      5'd0: v = 16'sd32767;
      5'd1: v = 16'sd32610;
      5'd2: v = 16'sd32138;
      5'd3: v = 16'sd31357;
      5'd4: v = 16'sd30274;
      5'd5: v = 16'sd28899;
      5'd6: v = 16'sd27246;
      5'd7: v = 16'sd25330;
      5'd8: v = 16'sd23170;
      5'd9: v = 16'sd20788;
      5'd10: v = 16'sd18205;
      5'd11: v = 16'sd15447;
      5'd12: v = 16'sd12540;
      5'd13: v = 16'sd9512;
      5'd14: v = 16'sd6393;
      5'd15: v = 16'sd3212;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [16:0] rom_cos(input logic [5:0] i);
    logic [1:0] q;
    logic [4:0] r;
    logic signed [16:0] v;
    q = i[5:4];
    r = {1'b0, i[3:0]};
    case (q)
      2'd0: v = 17'(quarter_cos(r));
      2'd1: v = -17'(quarter_cos(5'd16 - r));
      2'd2: v = -17'(quarter_cos(r));
      default: v = 17'(quarter_cos(5'd16 - r));
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/cdft_if.sv =====
interface cdft_in_if #(parameter int SAMPLE_BITS = 16);
  logic valid;
  logic ready;
  logic signed [SAMPLE_BITS-1:0] sample_real;
  logic signed [SAMPLE_BITS-1:0] sample_imag;
  modport source(output valid, sample_real, sample_imag, input ready);
  modport sink(input valid, sample_real, sample_imag, output ready);
endinterface

interface cdft_out_if;
  logic valid;
  logic ready;
  logic [5:0] bin_index;
  logic signed [23:0] bin_real;
  logic signed [23:0] bin_imag;
  logic [23:0] bin_magnitude;
  logic last_bin;
  modport source(output valid, bin_index, bin_real, bin_imag, bin_magnitude, last_bin,
                 input ready);
  modport sink(input valid, bin_index, bin_real, bin_imag, bin_magnitude, last_bin,
               output ready);
endinterface

// ===== hdl/cdft_ctrl.sv =====
module cdft_ctrl
  import cdft_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [6:0] n_pts,
  input  logic       out_ready,
  input  cdft_sts_t  sts,
  output cdft_cmd_t  cmd,
  output logic       in_ready,
  output logic       out_valid,
  output logic [5:0] k_idx,
  output logic [5:0] n_idx,
  output logic       last_k,
  output logic       wr_en,
  output logic [5:0] wr_addr
);

  cdft_state_t state_r, state_nxt;
  logic [6:0] fill_r, fill_nxt;
  logic [6:0] k_r, k_nxt;
  logic [6:0] n_r, n_nxt;
  logic [1:0] drain_r, drain_nxt;
  logic [6:0] fill_inc;

  assign fill_inc = fill_r + 7'd1;
  assign k_idx = k_r[5:0];
  assign n_idx = n_r[5:0];
  assign last_k = (k_r == n_pts - 7'd1);
  assign wr_en = in_fire;
  assign wr_addr = fill_r[5:0];

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r;
    k_nxt = k_r;
    n_nxt = n_r;
    drain_nxt = drain_r;
    case (state_r)
      ST_FILL: begin
        if (in_fire) begin
          if (fill_inc >= n_pts) begin
            fill_nxt = '0;
            k_nxt = '0;
            state_nxt = ST_CLEAR;
          end else begin
            fill_nxt = fill_inc;
          end
        end
      end
      ST_CLEAR: begin
        n_nxt = '0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        if (n_r == n_pts - 7'd1) begin
          drain_nxt = '0;
          state_nxt = ST_DRAIN;
        end else begin
          n_nxt = n_r + 7'd1;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 2'd1;
        if (drain_r == 2'd2) state_nxt = ST_SCALE;
      end
      ST_SCALE: state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (sts.sqrt_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (last_k) begin
            state_nxt = ST_FILL;
          end else begin
            k_nxt = k_r + 7'd1;
            state_nxt = ST_CLEAR;
          end
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_FILL: in_ready = 1'b1;
      ST_CLEAR: cmd.clear_acc = 1'b1;
      ST_MAC: cmd.mac_en = 1'b1;
      ST_SCALE: begin
        cmd.scale = 1'b1;
      end
      ST_SQRT: cmd.sqrt_step = 1'b1;
      ST_EMIT: begin
        out_valid = 1'b1;
      end
      default: ;
    endcase
    cmd.sqrt_start = (state_r == ST_SCALE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      fill_r <= '0;
      k_r <= '0;
      n_r <= '0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      k_r <= k_nxt;
      n_r <= n_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

// ===== hdl/cdft_dp.sv =====
module cdft_dp
  import cdft_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cdft_cmd_t                     cmd,
  output cdft_sts_t                     sts,
  input  logic                          wr_en,
  input  logic [5:0]                    wr_addr,
  input  logic signed [SAMPLE_BITS-1:0] wr_re,
  input  logic signed [SAMPLE_BITS-1:0] wr_im,
  input  logic [5:0]                    k_idx,
  input  logic [5:0]                    n_idx,
  input  logic [2:0]                    lp,
  input  logic                          inv,
  output logic signed [OUT_W-1:0]       res_re,
  output logic signed [OUT_W-1:0]       res_im,
  output logic [MAG_W-1:0]              res_mag
);

  localparam int TW = TWIDDLE_BITS + 1;
  localparam int PW = SAMPLE_BITS + TW;
  localparam int TSL = (TWIDDLE_BITS >= 16) ? TWIDDLE_BITS - 16 : 0;
  localparam int TSR = (TWIDDLE_BITS < 16) ? 16 - TWIDDLE_BITS : 0;

  logic signed [SAMPLE_BITS-1:0] mem_re [ROM_POINTS];
  logic signed [SAMPLE_BITS-1:0] mem_im [ROM_POINTS];
  logic signed [SAMPLE_BITS-1:0] xr_r, xi_r;
  logic signed [TW-1:0] c_r, s_r;
  logic signed [PW-1:0] p_rc_r, p_is_r, p_ic_r, p_rs_r;
  logic v1_r, v2_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic signed [OUT_W-1:0] re_r, im_r;
  logic [5:0] idx;
  logic [11:0] kn;
  logic signed [16:0] c_raw, s_raw;
  logic signed [ACC_W-1:0] t_re, t_im;
  logic signed [OUT_W-1:0] sat_re, sat_im;
  logic [SQ_W-1:0] sq_r, rem_r;
  logic [MAG_W-1:0] root_r;
  logic [MAG_W:0] bit_cnt_r;
  logic [SQ_W+1:0] rem_sh, test_v;

  assign kn = k_idx * n_idx;
  assign idx = 6'(kn << (3'd6 - lp));
  assign c_raw = rom_cos(idx);
  assign s_raw = rom_cos(idx + 6'd48);

  // Narrower twiddles truncate toward zero, wider ones scale up exactly.
  function automatic logic signed [TW-1:0] scale_tw(input logic signed [16:0] v);
    logic signed [16:0] tw_abs;
    tw_abs = (v < 0) ? -v : v;
    tw_abs = tw_abs >>> TSR;
    if (TWIDDLE_BITS >= 16) return TW'(v) <<< TSL;
    else return (v < 0) ? -TW'(tw_abs) : TW'(tw_abs);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [ACC_W-1:0] x);
    if (x > ACC_W'(8388607)) return 24'sh7FFFFF;
    if (x < -ACC_W'(8388608)) return -24'sh800000;
    return x[OUT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_re[wr_addr] <= wr_re;
      mem_im[wr_addr] <= wr_im;
    end
    xr_r <= mem_re[n_idx];
    xi_r <= mem_im[n_idx];
    c_r <= scale_tw(c_raw);
    s_r <= scale_tw(s_raw);
  end

  always_ff @(posedge clk) begin
    p_rc_r <= xr_r * c_r;
    p_is_r <= xi_r * s_r;
    p_ic_r <= xi_r * c_r;
    p_rs_r <= xr_r * s_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_en;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_acc) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v2_r) begin
      if (inv) begin
        acc_re_r <= acc_re_r + ACC_W'(p_rc_r) - ACC_W'(p_is_r);
        acc_im_r <= acc_im_r + ACC_W'(p_ic_r) + ACC_W'(p_rs_r);
      end else begin
        acc_re_r <= acc_re_r + ACC_W'(p_rc_r) + ACC_W'(p_is_r);
        acc_im_r <= acc_im_r + ACC_W'(p_ic_r) - ACC_W'(p_rs_r);
      end
    end
  end

  always_comb begin
    t_re = (acc_re_r + (ACC_W'(1) <<< (TWIDDLE_BITS - 2))) >>> (TWIDDLE_BITS - 1);
    t_im = (acc_im_r + (ACC_W'(1) <<< (TWIDDLE_BITS - 2))) >>> (TWIDDLE_BITS - 1);
    if (inv) begin
      t_re = t_re >>> lp;
      t_im = t_im >>> lp;
    end
    sat_re = sat(t_re);
    sat_im = sat(t_im);
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      re_r <= sat_re;
      im_r <= sat_im;
    end
  end

  // Restoring square root, one result bit per cycle.
  assign rem_sh = {rem_r, sq_r[SQ_W-1:SQ_W-2]};
  assign test_v = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r <= '0;
    end else if (cmd.sqrt_start) begin
      bit_cnt_r <= {1'b1, {MAG_W{1'b0}}};
    end else if (cmd.sqrt_step && bit_cnt_r != '0) begin
      bit_cnt_r <= bit_cnt_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_r <= SQ_W'(sat_re * sat_re) + SQ_W'(sat_im * sat_im);
      rem_r <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step && bit_cnt_r > 1) begin
      sq_r <= sq_r << 2;
      if (rem_sh >= test_v) begin
        rem_r <= SQ_W'(rem_sh - test_v);
        root_r <= {root_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_r <= SQ_W'(rem_sh);
        root_r <= {root_r[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign sts.sqrt_done = (bit_cnt_r == 1);
  assign res_re = re_r;
  assign res_im = im_r;
  assign res_mag = root_r;

endmodule

// ===== hdl/complex_dft_idft_engine.sv =====
// Direct complex DFT and inverse DFT engine.
// Samples arrive on the in channel, one complex item per handshake; the
// frame length is 2^log_points, set through the cfg port while idle.
// The item that completes a frame starts the transform; no further input
// item is taken until every bin has been delivered.
// Each bin is cleared, multiply-accumulated over the N items, drained from
// the multiplier pipeline and scaled, then goes through a bit-serial square
// root and is emitted; the next bin starts once the previous one is taken.
// One shared complex multiplier does all N*N products.
// A log_points of 0 acts as 1, and one above 6 or log2(MAX_POINTS) is capped.
// Bins leave the out channel in order of k with last_bin set on bin N-1.
// A stalled receiver holds the current bin; the engine waits for it.
// Reset clears the fill count and restores log_points to 6 and forward mode.
// Unwritten sample storage is never read by the fill order.
module complex_dft_idft_engine
  import cdft_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  cdft_in_if.sink      in_ch,
  cdft_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [2:0]   cfg_data
);

  localparam logic [2:0] MAX_LOG = 3'($clog2(MAX_POINTS));

  logic [2:0] log_r;
  logic inv_r;
  logic [2:0] lp;
  logic [6:0] n_pts;
  logic in_fire, last_k, wr_en;
  logic [5:0] k_idx, n_idx, wr_addr;
  cdft_cmd_t cmd;
  cdft_sts_t sts;
  logic signed [OUT_W-1:0] res_re, res_im;
  logic [MAG_W-1:0] res_mag;

  always_comb begin
    lp = (log_r == 3'd0) ? 3'd1 : log_r;
    if (lp > 3'd6) lp = 3'd6;
    if (lp > MAX_LOG) lp = MAX_LOG;
  end
  assign n_pts = 7'd1 << lp;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_r <= 3'd6;
      inv_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LOG) log_r <= cfg_data;
      else if (cfg_index == CFG_INV) inv_r <= cfg_data[0];
    end
  end

  cdft_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .n_pts, .out_ready(out_ch.ready), .sts, .cmd,
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .k_idx, .n_idx, .last_k,
    .wr_en, .wr_addr
  );

  cdft_dp #(.SAMPLE_BITS(SAMPLE_BITS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .wr_en, .wr_addr, .wr_re(in_ch.sample_real),
    .wr_im(in_ch.sample_imag), .k_idx, .n_idx, .lp, .inv(inv_r), .res_re,
    .res_im, .res_mag
  );

  assign out_ch.bin_index = k_idx;
  assign out_ch.bin_real = res_re;
  assign out_ch.bin_imag = res_im;
  assign out_ch.bin_magnitude = res_mag;
  assign out_ch.last_bin = last_k;

  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("input taken while bin pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.bin_real))
    else $error("bin changed under stall");
  a_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.bin_real == 0 && out_ch.bin_imag == 0 |->
    out_ch.bin_magnitude == 0) else $error("magnitude of zero bin");

endmodule

// ===== sim/cdft_test_if.sv =====
interface cdft_test_clk_if;
  logic clk;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end
endinterface

// ===== sim/complex_dft_idft_engine_test.sv =====
module complex_dft_idft_engine_test
  import cdft_pkg::*;
();

  typedef struct packed {
    logic [5:0] index;
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic [23:0] mag;
    logic last;
  } bin_t;

  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [2:0] cfg_data;

  cdft_test_clk_if clk_if();
  cdft_in_if #(.SAMPLE_BITS(16)) in_ch();
  cdft_out_if out_ch();

  assign clk = clk_if.clk;

  complex_dft_idft_engine u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [2:0] log_len;
  logic inv_on;
  logic signed [15:0] frame_re [64];
  logic signed [15:0] frame_im [64];
  int fill;
  bin_t expected_bins [$];
  int errors;
  int bins_seen;
  int items_sent;
  int idle_cycles;
  int out_wait;
  bit stall_random;

  function automatic int rom_cos_local(int i);
    int q;
    int r;
    int quarter [17];
    quarter = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
                20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
    q = (i >> 4) & 3;
    r = i & 15;
    case (q)
      0: return quarter[r];
      1: return -quarter[16 - r];
      2: return -quarter[r];
      default: return quarter[16 - r];
    endcase
  endfunction

  function automatic longint twiddle_cos(int i);
    return longint'(rom_cos_local(i));
  endfunction

  function automatic longint floor_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint sat24(longint x);
    if (x > 8388607) return 8388607;
    if (x < -8388608) return -8388608;
    return x;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int frame_log();
    if (log_len < 1) return 1;
    if (log_len > 6) return 6;
    return log_len;
  endfunction

  task automatic compute_spectrum(int lp);
    int npts;
    int stride;
    int idx;
    longint acc_re;
    longint acc_im;
    longint c;
    longint s;
    longint re;
    longint im;
    bin_t b;
    npts = 1 << lp;
    stride = 64 >> lp;
    for (int k = 0; k < npts; k++) begin
      acc_re = 0;
      acc_im = 0;
      for (int n = 0; n < npts; n++) begin
        idx = (k * n * stride) & 63;
        c = twiddle_cos(idx);
        s = twiddle_cos((idx + 48) & 63);
        if (inv_on) begin
          acc_re += frame_re[n] * c - frame_im[n] * s;
          acc_im += frame_im[n] * c + frame_re[n] * s;
        end else begin
          acc_re += frame_re[n] * c + frame_im[n] * s;
          acc_im += frame_im[n] * c - frame_re[n] * s;
        end
      end
      re = floor_shr(acc_re + (64'sd1 <<< 14), 15);
      im = floor_shr(acc_im + (64'sd1 <<< 14), 15);
      if (inv_on) begin
        re = floor_shr(re, lp);
        im = floor_shr(im, lp);
      end
      re = sat24(re);
      im = sat24(im);
      b.index = k[5:0];
      b.re = re[23:0];
      b.im = im[23:0];
      b.mag = 24'(int_sqrt(longint'(re * re) + longint'(im * im)));
      b.last = (k == npts - 1);
      expected_bins.push_back(b);
    end
  endtask

  task automatic wait_cycles(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
    int lp;
    int gap;
    gap = stall_random ? int'($urandom_range(0, 16)) : 0;
    if (gap > 0) wait_cycles(gap);
    in_ch.valid <= 1'b1;
    in_ch.sample_real <= re;
    in_ch.sample_imag <= im;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    lp = frame_log();
    frame_re[fill & 63] = re;
    frame_im[fill & 63] = im;
    fill = (fill + 1) & 127;
    if (fill >= (1 << lp)) begin
      fill = 0;
      compute_spectrum(lp);
    end
  endtask

  task automatic wait_drained();
    wait_cycles(1);
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [2:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_LOG) log_len = val;
    else inv_on = val[0];
  endtask

  task automatic send_frame(int kind);
    int npts;
    npts = 1 << frame_log();
    for (int n = 0; n < npts; n++) begin
      case (kind)
        0: send_sample(16'sh7fff, 16'sh7fff);
        1: send_sample(16'sh8000, 16'sh8000);
        2: send_sample(n == 0 ? 16'sh7fff : 16'sd0, n == 0 ? 16'sh8000 : 16'sd0);
        3: send_sample((n & 1) ? 16'sh8000 : 16'sh7fff, 16'sd0);
        default: send_sample(16'($urandom), 16'($urandom));
      endcase
    end
  endtask

  task automatic test_directed();
    stall_random = 0;
    write_reg(CFG_LOG, 3'd1);
    write_reg(CFG_INV, 1'b0);
    for (int kind = 0; kind < 4; kind++) send_frame(kind);
    wait_drained();
    write_reg(CFG_INV, 1'b1);
    for (int kind = 0; kind < 4; kind++) send_frame(kind);
    wait_drained();
    write_reg(CFG_LOG, 3'd0);
    send_frame(0);
    wait_drained();
    write_reg(CFG_LOG, 3'd7);
    write_reg(CFG_INV, 1'b0);
    send_frame(0);
    wait_drained();
  endtask

  task automatic test_random_frames();
    int target;
    target = items_sent + 90;
    while (items_sent < target) begin
      stall_random = $urandom_range(0, 3) != 0;
      write_reg(CFG_LOG, 3'($urandom_range(1, 5)));
      write_reg(CFG_INV, 1'($urandom));
      repeat ($urandom_range(1, 3)) send_frame(4);
      wait_drained();
    end
  endtask

  task automatic test_length_change_mid_frame();
    stall_random = 1;
    write_reg(CFG_LOG, 3'd3);
    write_reg(CFG_INV, 1'b0);
    send_frame(4);
    wait_drained();
    repeat (5) send_sample(16'($urandom), 16'($urandom));
    wait_cycles(20);
    write_reg(CFG_LOG, 3'd2);
    send_sample(16'($urandom), 16'($urandom));
    wait_drained();
    write_reg(CFG_LOG, 3'd6);
    send_frame(4);
    wait_drained();
  endtask

  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_wait <= 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) w = stall_random ? int'($urandom_range(0, 16)) : 0;
      else w = (out_wait > 0) ? out_wait - 1 : 0;
      out_wait <= w;
      out_ch.ready <= (w == 0);
    end
  end

  always @(posedge clk) begin
    bin_t exp_bin;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bins_seen++;
      if (expected_bins.size() == 0) begin
        $display("%0t unexpected bin %0d", $time, out_ch.bin_index);
        errors++;
      end else begin
        exp_bin = expected_bins.pop_front();
        if (out_ch.bin_index !== exp_bin.index || out_ch.bin_real !== exp_bin.re ||
            out_ch.bin_imag !== exp_bin.im || out_ch.bin_magnitude !== exp_bin.mag ||
            out_ch.last_bin !== exp_bin.last) begin
          $display("%0t expected k=%0d re=%0d im=%0d mag=%0d last=%0b", $time,
                   exp_bin.index, exp_bin.re, exp_bin.im, exp_bin.mag, exp_bin.last);
          $display("%0t actual   k=%0d re=%0d im=%0d mag=%0d last=%0b", $time,
                   out_ch.bin_index, out_ch.bin_real, out_ch.bin_imag,
                   out_ch.bin_magnitude, out_ch.last_bin);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("complex_dft_idft_engine: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = 3'd0;
    in_ch.valid = 1'b0;
    in_ch.sample_real = '0;
    in_ch.sample_imag = '0;
    log_len = 3'd6;
    inv_on = 1'b0;
    fill = 0;
    errors = 0;
    bins_seen = 0;
    items_sent = 0;
    idle_cycles = 0;
    stall_random = 0;
    wait_cycles(10);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_length_change_mid_frame();
    test_random_frames();
    wait_drained();
    $display("Sent %0d samples and checked %0d bins over lengths 2 to 64,", items_sent,
             bins_seen);
    $display("forward and inverse, with random stalls on both channels.");
    if (errors == 0 && expected_bins.size() == 0) begin
      $display("complex_dft_idft_engine: match");
    end else begin
      $display("complex_dft_idft_engine: mismatch");
    end
    $finish;
  end

endmodule
